// File: sv/set_assoc_cache_fifo_lfu_macros.svh
// Assertion macros for the set-associative cache checker.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef SET_ASSOC_CACHE_FIFO_LFU_MACROS_SVH
`define SET_ASSOC_CACHE_FIFO_LFU_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SACFL_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SACFL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/sacfl_pkg.sv
// Shared widths, limits and policy codes for the set-associative cache.
// No dependencies; used by the cache top level and its testbench.
package sacfl_pkg;

  localparam int TAG_W     = 8;
  localparam int IDX_W     = 8;
  localparam int IDX_SPAN  = 1 << IDX_W;
  localparam int KEY_W     = TAG_W + IDX_W;
  localparam int CNT_W     = 16;
  localparam int HIT_W     = 16;
  localparam int WAY_OUT_W = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [HIT_W-1:0] HIT_MAX = {HIT_W{1'b1}};

  localparam logic MODE_FIFO = 1'b0;
  localparam logic MODE_FREQ = 1'b1;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [CNT_W-1:0] cnt_t;

endpackage

// File: sv/set_assoc_cache_fifo_lfu.sv
// Set-associative cache lookup with FIFO or hit-count replacement; uses sacfl_pkg.
// An accepted start is registered into busy, and out_valid is registered from busy.
// A new word is not taken while busy is high; busy is high for the one cycle in which
// the set row read from memory is compared, updated and written back.
// Reset clears valid bits, hit total and policy; no clearing pass is needed.
// Results are strobed for one cycle; the receiver cannot stall them.
module set_assoc_cache_fifo_lfu #(
  parameter int NUM_SETS = 8,
  parameter int NUM_WAYS = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [sacfl_pkg::TAG_W-1:0]     in_access_tag,
  input  logic [sacfl_pkg::IDX_W-1:0]     in_access_index,
  output logic                            out_valid,
  output logic                            out_was_hit,
  output logic [sacfl_pkg::WAY_OUT_W-1:0] out_way_used,
  output logic                            out_evicted_valid,
  output logic [sacfl_pkg::HIT_W-1:0]     out_hit_total,
  input  logic                            cfg_we,
  input  logic                            cfg_policy_mode
);

  import sacfl_pkg::*;

  localparam int SET_W   = $clog2(NUM_SETS);
  localparam int WAY_W   = $clog2(NUM_WAYS);
  localparam int WAYS_P2 = 1 << WAY_W;

  typedef logic [SET_W-1:0] set_lut_t [IDX_SPAN];
  typedef logic [NUM_WAYS-1:0][KEY_W-1:0] key_row_t;
  typedef logic [NUM_WAYS-1:0][CNT_W-1:0] cnt_row_t;
  typedef struct packed {
    key_row_t keys;
    cnt_row_t cnts;
  } freq_row_t;

  function automatic set_lut_t build_set_lut();
    set_lut_t lut;
    for (int i = 0; i < IDX_SPAN; i++) begin
      lut[i] = SET_W'(i % NUM_SETS);
    end
    return lut;
  endfunction

  localparam set_lut_t SET_LUT = build_set_lut();

  key_row_t  fifo_mem [NUM_SETS];
  freq_row_t freq_mem [NUM_SETS];

  logic [NUM_WAYS-1:0] fifo_vld_r [NUM_SETS];
  logic [NUM_WAYS-1:0] freq_vld_r [NUM_SETS];

  key_row_t            fifo_rd_r;
  freq_row_t           freq_rd_r;
  logic                busy_r;
  logic [SET_W-1:0]    set_r;
  key_t                key_r;
  logic                mode_r;
  logic [HIT_W-1:0]    hit_cnt_r;
  logic [HIT_W-1:0]    hit_cnt_nxt;
  logic                out_valid_r;
  logic                out_hit_r;
  logic [WAY_W-1:0]    out_way_r;
  logic                out_evict_r;
  logic [HIT_W-1:0]    out_total_r;

  logic                accept;
  logic [SET_W-1:0]    acc_set;
  logic [NUM_WAYS-1:0] vld_row;
  logic [NUM_WAYS-1:0] vld_nxt;
  key_row_t            keys_row;
  logic [NUM_WAYS-1:0] match;
  logic                any_hit;
  logic                any_free;
  logic [WAY_W-1:0]    hit_way;
  logic [WAY_W-1:0]    free_way;
  logic [WAY_W-1:0]    min_way;
  logic [WAY_W-1:0]    way_sel;
  logic                evict;
  key_row_t            fifo_row_nxt;
  freq_row_t           freq_row_nxt;
  cnt_t                tcnt [WAY_W+1][WAYS_P2];
  logic [WAY_W-1:0]    tidx [WAY_W+1][WAYS_P2];

  assign accept  = start & ~busy_r;
  assign acc_set = SET_LUT[in_access_index];
  assign busy    = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_FIFO;
    end else if (cfg_we) begin
      mode_r <= cfg_policy_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      set_r     <= acc_set;
      key_r     <= {in_access_tag, in_access_index};
      fifo_rd_r <= fifo_mem[acc_set];
      freq_rd_r <= freq_mem[acc_set];
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r && mode_r == MODE_FIFO) begin
      fifo_mem[set_r] <= fifo_row_nxt;
    end
    if (busy_r && mode_r == MODE_FREQ) begin
      freq_mem[set_r] <= freq_row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NUM_SETS; s++) begin
        fifo_vld_r[s] <= '0;
        freq_vld_r[s] <= '0;
      end
    end else if (busy_r) begin
      if (mode_r == MODE_FIFO) begin
        fifo_vld_r[set_r] <= vld_nxt;
      end else begin
        freq_vld_r[set_r] <= vld_nxt;
      end
    end
  end

  always_comb begin
    vld_row  = (mode_r == MODE_FIFO) ? fifo_vld_r[set_r] : freq_vld_r[set_r];
    keys_row = (mode_r == MODE_FIFO) ? fifo_rd_r : freq_rd_r.keys;
    for (int w = 0; w < NUM_WAYS; w++) begin
      match[w] = vld_row[w] && (keys_row[w] == key_r);
    end
    any_hit  = |match;
    any_free = ~&vld_row;
    hit_way  = '0;
    free_way = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_way = WAY_W'(w);
      end
      if (!vld_row[w]) begin
        free_way = WAY_W'(w);
      end
    end
  end

  // Pairwise minimum tree; ties keep the lower way.
  always_comb begin
    for (int l = 0; l <= WAY_W; l++) begin
      for (int i = 0; i < WAYS_P2; i++) begin
        tcnt[l][i] = CNT_MAX;
        tidx[l][i] = '0;
      end
    end
    for (int i = 0; i < WAYS_P2; i++) begin
      tcnt[0][i] = (i < NUM_WAYS) ? freq_rd_r.cnts[i] : CNT_MAX;
      tidx[0][i] = WAY_W'(i);
    end
    for (int l = 0; l < WAY_W; l++) begin
      for (int i = 0; i < (WAYS_P2 >> (l + 1)); i++) begin
        if (tcnt[l][2*i+1] < tcnt[l][2*i]) begin
          tcnt[l+1][i] = tcnt[l][2*i+1];
          tidx[l+1][i] = tidx[l][2*i+1];
        end else begin
          tcnt[l+1][i] = tcnt[l][2*i];
          tidx[l+1][i] = tidx[l][2*i];
        end
      end
    end
    min_way = tidx[WAY_W][0];
  end

  always_comb begin
    fifo_row_nxt = fifo_rd_r;
    freq_row_nxt = freq_rd_r;
    vld_nxt      = vld_row;
    way_sel      = hit_way;
    evict        = 1'b0;
    if (any_hit) begin
      if (freq_rd_r.cnts[hit_way] != CNT_MAX) begin
        freq_row_nxt.cnts[hit_way] = freq_rd_r.cnts[hit_way] + CNT_W'(1);
      end
    end else if (any_free) begin
      way_sel                     = free_way;
      vld_nxt[free_way]           = 1'b1;
      fifo_row_nxt[free_way]      = key_r;
      freq_row_nxt.keys[free_way] = key_r;
      freq_row_nxt.cnts[free_way] = '0;
    end else begin
      evict = 1'b1;
      if (mode_r == MODE_FIFO) begin
        way_sel = WAY_W'(NUM_WAYS - 1);
        for (int w = 0; w < NUM_WAYS - 1; w++) begin
          fifo_row_nxt[w] = fifo_rd_r[w+1];
        end
        fifo_row_nxt[NUM_WAYS-1] = key_r;
      end else begin
        way_sel                    = min_way;
        freq_row_nxt.keys[min_way] = key_r;
        freq_row_nxt.cnts[min_way] = '0;
      end
    end
    hit_cnt_nxt = (any_hit && hit_cnt_r != HIT_MAX) ? hit_cnt_r + HIT_W'(1) : hit_cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= busy_r;
      if (busy_r) begin
        hit_cnt_r <= hit_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      out_hit_r   <= any_hit;
      out_way_r   <= way_sel;
      out_evict_r <= evict;
      out_total_r <= hit_cnt_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_was_hit       = out_hit_r;
  assign out_way_used      = WAY_OUT_W'(out_way_r);
  assign out_evicted_valid = out_evict_r;
  assign out_hit_total     = out_total_r;

endmodule

// File: sv/sacfl_checker.sv
// Port-level checker for the set-associative cache and its bind statement.
// Depends on set_assoc_cache_fifo_lfu_macros.svh and the top level's port names.
`include "set_assoc_cache_fifo_lfu_macros.svh"

module sacfl_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic out_was_hit,
  input logic out_evicted_valid
);

  `SACFL_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
  `SACFL_ASSERT_IMPL(a_accept_result, start && !busy, ##2 out_valid, "no result two cycles after accept")
  `SACFL_ASSERT_NEXT(a_busy_single, busy, !busy && out_valid, "busy not followed by a result")
  `SACFL_ASSERT_IMPL(a_hit_no_evict, out_valid && out_was_hit, !out_evicted_valid, "hit reported an eviction")

endmodule

bind set_assoc_cache_fifo_lfu sacfl_checker u_sacfl_checker (.*);

// File: test/tb_set_assoc_cache_fifo_lfu.sv
// Self-checking testbench for set_assoc_cache_fifo_lfu: directed and random accesses in
// both replacement policies, checked against a cycle-free model of the cache sets.
// Depends on sacfl_pkg and the set_assoc_cache_fifo_lfu module.
module tb_set_assoc_cache_fifo_lfu;
  import sacfl_pkg::*;

  localparam int SETS = 8;
  localparam int WAYS = 4;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 4;
  localparam int HAMMER_HITS = 20;

  typedef struct packed {
    logic                 was_hit;
    logic [WAY_OUT_W-1:0] way_used;
    logic                 evicted_valid;
    logic [HIT_W-1:0]     hit_total;
  } lookup_t;

  class cache_mirror;
    logic             policy;
    key_t             fifo_keys [SETS][WAYS];
    bit               fifo_valid [SETS][WAYS];
    key_t             freq_keys [SETS][WAYS];
    bit               freq_valid [SETS][WAYS];
    cnt_t             freq_counts [SETS][WAYS];
    logic [HIT_W-1:0] hits_seen;
    lookup_t          pending_lookups [$];
    int               errors;

    function new();
      policy = MODE_FIFO;
      hits_seen = '0;
      errors = 0;
      foreach (fifo_valid[s, w]) begin
        fifo_valid[s][w] = 1'b0;
        freq_valid[s][w] = 1'b0;
        freq_counts[s][w] = '0;
      end
    endfunction

    function void set_policy(logic mode);
      policy = mode;
    endfunction

    function int pending();
      return pending_lookups.size();
    endfunction

    function void note_access(logic [TAG_W-1:0] tag, logic [IDX_W-1:0] idx);
      key_t    key;
      int      s;
      int      way;
      lookup_t exp;
      key = {tag, idx};
      s = int'(idx) % SETS;
      way = -1;
      exp = '0;
      if (policy == MODE_FIFO) begin
        for (int w = 0; w < WAYS; w++)
          if (way < 0 && fifo_valid[s][w] && fifo_keys[s][w] == key) way = w;
        if (way >= 0) begin
          exp.was_hit = 1'b1;
        end else begin
          for (int w = 0; w < WAYS; w++)
            if (way < 0 && !fifo_valid[s][w]) way = w;
          if (way < 0) begin
            for (int w = 0; w < WAYS - 1; w++) begin
              fifo_keys[s][w] = fifo_keys[s][w+1];
              fifo_valid[s][w] = fifo_valid[s][w+1];
            end
            way = WAYS - 1;
            exp.evicted_valid = 1'b1;
          end
          fifo_keys[s][way] = key;
          fifo_valid[s][way] = 1'b1;
        end
      end else begin
        for (int w = 0; w < WAYS; w++)
          if (way < 0 && freq_valid[s][w] && freq_keys[s][w] == key) way = w;
        if (way >= 0) begin
          exp.was_hit = 1'b1;
          if (freq_counts[s][way] != CNT_MAX) freq_counts[s][way]++;
        end else begin
          for (int w = 0; w < WAYS; w++)
            if (way < 0 && !freq_valid[s][w]) way = w;
          if (way < 0) begin
            way = 0;
            for (int w = 1; w < WAYS; w++)
              if (freq_counts[s][w] < freq_counts[s][way]) way = w;
            exp.evicted_valid = 1'b1;
          end
          freq_keys[s][way] = key;
          freq_valid[s][way] = 1'b1;
          freq_counts[s][way] = '0;
        end
      end
      if (exp.was_hit && hits_seen != HIT_MAX) hits_seen++;
      exp.way_used = WAY_OUT_W'(way);
      exp.hit_total = hits_seen;
      pending_lookups.push_back(exp);
    endfunction

    function void compare_field(string name, int unsigned exp, int unsigned act);
      if (exp != act) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
        errors++;
      end
    endfunction

    function void check_result(lookup_t got);
      lookup_t exp;
      if (pending_lookups.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      exp = pending_lookups.pop_front();
      compare_field("was_hit", 32'(exp.was_hit), 32'(got.was_hit));
      compare_field("way_used", 32'(exp.way_used), 32'(got.way_used));
      compare_field("evicted_valid", 32'(exp.evicted_valid), 32'(got.evicted_valid));
      compare_field("hit_total", 32'(exp.hit_total), 32'(got.hit_total));
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [TAG_W-1:0]     in_access_tag = '0;
  logic [IDX_W-1:0]     in_access_index = '0;
  logic                 out_valid;
  logic                 out_was_hit;
  logic [WAY_OUT_W-1:0] out_way_used;
  logic                 out_evicted_valid;
  logic [HIT_W-1:0]     out_hit_total;
  logic                 cfg_we = 1'b0;
  logic                 cfg_policy_mode = 1'b0;
  int unsigned          cycle_count = 0;

  cache_mirror mirror = new();

  set_assoc_cache_fifo_lfu #(
    .NUM_SETS(SETS),
    .NUM_WAYS(WAYS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_access_tag(in_access_tag),
    .in_access_index(in_access_index),
    .out_valid(out_valid),
    .out_was_hit(out_was_hit),
    .out_way_used(out_way_used),
    .out_evicted_valid(out_evicted_valid),
    .out_hit_total(out_hit_total),
    .cfg_we(cfg_we),
    .cfg_policy_mode(cfg_policy_mode)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) mirror.set_policy(cfg_policy_mode);
      if (start && !busy) mirror.note_access(in_access_tag, in_access_index);
      if (out_valid)
        mirror.check_result(lookup_t'({out_was_hit, out_way_used, out_evicted_valid,
                                       out_hit_total}));
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Leaves start high on return so that back-to-back words need no toggle.
  task automatic send_access(input logic [TAG_W-1:0] tag, input logic [IDX_W-1:0] idx);
    start <= 1'b1;
    in_access_tag <= tag;
    in_access_index <= idx;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic pause_sender(input int idle_pct);
    int n;
    n = 0;
    while (n < 40 && $urandom_range(99) < idle_pct) n++;
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic write_policy(input logic mode);
    start <= 1'b0;
    while (mirror.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_policy_mode <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly a small pool of tags and two index values per set, so that sets fill,
  // hit and evict; the rest is fully random.
  task automatic send_random(input int idle_pct);
    logic [TAG_W-1:0] tag;
    logic [IDX_W-1:0] idx;
    if ($urandom_range(99) < 15) begin
      tag = TAG_W'($urandom);
      idx = IDX_W'($urandom);
    end else begin
      tag = TAG_W'($urandom_range(0, $urandom_range(0, 5)));
      idx = IDX_W'(($urandom_range(0, 1) * SETS) + $urandom_range(0, SETS - 1));
    end
    pause_sender(idle_pct);
    send_access(tag, idx);
  endtask

  initial begin
    int idle_pct [4];
    idle_pct = '{0, 79, 0, 24};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_policy(MODE_FIFO);
    send_access(8'h00, 8'h00);
    send_access(8'hFF, 8'h00);
    send_access(8'h00, 8'h08);
    send_access(8'hFF, 8'hF8);
    send_access(8'h00, 8'h00);
    send_access(8'h12, 8'h00);
    send_access(8'h00, 8'h00);
    send_access(8'hFF, 8'hF8);
    send_access(8'hFF, 8'hFF);

    write_policy(MODE_FREQ);
    send_access(8'h01, 8'h07);
    send_access(8'h02, 8'h07);
    send_access(8'h03, 8'h07);
    send_access(8'h04, 8'h0F);
    send_access(8'h02, 8'h07);
    send_access(8'h02, 8'h07);
    send_access(8'h01, 8'h07);
    send_access(8'h04, 8'h0F);
    send_access(8'h05, 8'h07);
    send_access(8'h06, 8'hFF);
    send_access(8'hFF, 8'hFF);
    send_access(8'h00, 8'h00);
    send_access(8'h03, 8'h07);

    for (int phase = 0; phase < 4; phase++) begin
      write_policy(phase[0] ? MODE_FREQ : MODE_FIFO);
      repeat (190) send_random(idle_pct[phase]);
    end

    // Repeated hits raise one way's use count before the set fills and evicts.
    write_policy(MODE_FREQ);
    repeat (HAMMER_HITS) send_access(8'h3C, 8'h05);
    send_access(8'h40, 8'h05);
    send_access(8'h41, 8'h0D);
    send_access(8'h42, 8'h05);
    send_access(8'h43, 8'h05);
    send_access(8'h3C, 8'h05);
    repeat (25) send_random(24);

    write_policy(MODE_FIFO);
    repeat (25) send_random(24);

    start <= 1'b0;
    while (mirror.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mirror.pending() != 0) begin
      $display("%0t: %0d result words never arrived", $time, mirror.pending());
      mirror.errors++;
    end
    if (mirror.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// File: sim.f
+incdir+sv
sv/sacfl_pkg.sv
sv/set_assoc_cache_fifo_lfu.sv
sv/sacfl_checker.sv
test/tb_set_assoc_cache_fifo_lfu.sv
